// ===== hw/rtl/bfr_pkg.sv =====
// Package for the bitmap font text renderer.
// Holds the glyph record, the font table, register codes and sequencer states.
// No dependencies.
package bfr_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int COLOR_W = 24;
	localparam int FIELD_W = 16;
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_NEWLINE = 7'h0A;
	localparam logic [6:0] CH_LAST_PRINT = 7'h7E;
	localparam logic [2:0] LINE_H = 3'd7;
	localparam int LINE_ADV = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEXT_COLOR = 3'd0,
		REG_CLIP_X0 = 3'd1,
		REG_CLIP_Y0 = 3'd2,
		REG_CLIP_WIDTH = 3'd3,
		REG_CLIP_HEIGHT = 3'd4,
		REG_MODE_FLAGS = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic [2:0] w;
		logic [2:0] off;
		logic [2:0] n;
		logic [6:0][4:0] rows;
	} glyph_t;

	// Cell position handed to the cell unit each scan cycle.
	typedef struct packed {
		logic inv;
		logic [2:0] x;
		logic [2:0] y;
	} cell_req_t;

	// Control from the sequencer into the output stage.
	typedef struct packed {
		logic push;
		logic flush;
	} ostage_ctrl_t;

	// Status back from the output stage.
	typedef struct packed {
		logic push_ok;
		logic pend_v;
	} ostage_stat_t;

	function automatic glyph_t mk(input int w, input int off, input int n,
			input int r0, input int r1, input int r2, input int r3,
			input int r4, input int r5, input int r6);
		glyph_t g;
		g.w = 3'(w);
		g.off = 3'(off);
		g.n = 3'(n);
		g.rows[0] = 5'(r0);
		g.rows[1] = 5'(r1);
		g.rows[2] = 5'(r2);
		g.rows[3] = 5'(r3);
		g.rows[4] = 5'(r4);
		g.rows[5] = 5'(r5);
		g.rows[6] = 5'(r6);
		return g;
	endfunction

	function automatic glyph_t glyph_lookup(input logic [6:0] ch);
		glyph_t g;
		case (ch)
			7'h20: g = mk(3,7,0,0,0,0,0,0,0,0);
			7'h21: g = mk(1,2,6,1,1,1,1,0,1,0);
			7'h22: g = mk(3,6,2,5,5,0,0,0,0,0);
			7'h23: g = mk(5,1,7,10,10,31,10,31,10,10);
			7'h24: g = mk(3,1,7,2,7,4,7,1,7,2);
			7'h25: g = mk(5,2,5,25,26,4,11,19,0,0);
			7'h26: g = mk(5,2,5,8,20,13,18,13,0,0);
			7'h27: g = mk(1,6,2,1,1,0,0,0,0,0);
			7'h28: g = mk(2,1,7,1,2,2,2,2,2,1);
			7'h29: g = mk(2,1,7,2,1,1,1,1,1,2);
			7'h2A: g = mk(3,5,3,5,2,5,0,0,0,0);
			7'h2B: g = mk(3,3,3,2,7,2,0,0,0,0);
			7'h2C: g = mk(2,1,2,1,2,0,0,0,0,0);
			7'h2D: g = mk(3,4,1,7,0,0,0,0,0,0);
			7'h2E: g = mk(1,1,1,1,0,0,0,0,0,0);
			7'h2F: g = mk(3,2,6,1,1,2,2,4,4,0);
			7'h30: g = mk(3,2,5,7,5,5,5,7,0,0);
			7'h31: g = mk(3,2,5,6,2,2,2,7,0,0);
			7'h32: g = mk(3,2,5,7,1,7,4,7,0,0);
			7'h33: g = mk(3,2,5,7,1,7,1,7,0,0);
			7'h34: g = mk(3,2,5,5,5,7,1,1,0,0);
			7'h35: g = mk(3,2,5,7,4,7,1,7,0,0);
			7'h36: g = mk(3,2,5,7,4,7,5,7,0,0);
			7'h37: g = mk(3,2,5,7,1,1,1,1,0,0);
			7'h38: g = mk(3,2,5,7,5,7,5,7,0,0);
			7'h39: g = mk(3,2,5,7,5,7,1,7,0,0);
			7'h3A: g = mk(1,3,4,1,0,0,1,0,0,0);
			7'h3B: g = mk(1,2,5,1,0,0,1,1,0,0);
			7'h3C: g = mk(3,2,5,1,2,4,2,1,0,0);
			7'h3D: g = mk(3,3,3,7,0,7,0,0,0,0);
			7'h3E: g = mk(3,2,5,4,2,1,2,4,0,0);
			7'h3F: g = mk(4,2,6,14,1,6,4,0,4,0);
			7'h40: g = mk(5,1,7,14,17,23,21,23,16,15);
			7'h41: g = mk(4,2,5,6,9,15,9,9,0,0);
			7'h42: g = mk(4,2,5,14,9,14,9,14,0,0);
			7'h43: g = mk(4,2,5,6,9,8,9,6,0,0);
			7'h44: g = mk(4,2,5,14,9,9,9,14,0,0);
			7'h45: g = mk(3,2,5,7,4,6,4,7,0,0);
			7'h46: g = mk(3,2,5,7,4,6,4,4,0,0);
			7'h47: g = mk(4,2,5,6,8,11,9,6,0,0);
			7'h48: g = mk(4,2,5,9,9,15,9,9,0,0);
			7'h49: g = mk(3,2,5,7,2,2,2,7,0,0);
			7'h4A: g = mk(3,2,5,7,1,1,1,6,0,0);
			7'h4B: g = mk(4,2,5,9,10,12,10,9,0,0);
			7'h4C: g = mk(3,2,5,4,4,4,4,7,0,0);
			7'h4D: g = mk(5,2,5,17,27,21,17,17,0,0);
			7'h4E: g = mk(5,2,5,17,25,21,19,17,0,0);
			7'h4F: g = mk(4,2,5,6,9,9,9,6,0,0);
			7'h50: g = mk(4,2,5,14,9,14,8,8,0,0);
			7'h51: g = mk(4,2,5,6,9,9,10,5,0,0);
			7'h52: g = mk(4,2,5,14,9,14,9,9,0,0);
			7'h53: g = mk(4,2,5,7,8,15,1,14,0,0);
			7'h54: g = mk(5,2,5,31,4,4,4,4,0,0);
			7'h55: g = mk(4,2,5,9,9,9,9,6,0,0);
			7'h56: g = mk(5,2,5,17,17,10,10,4,0,0);
			7'h57: g = mk(5,2,5,17,17,21,27,17,0,0);
			7'h58: g = mk(3,2,5,5,5,2,5,5,0,0);
			7'h59: g = mk(3,2,5,5,5,2,2,2,0,0);
			7'h5A: g = mk(4,2,5,15,1,6,8,15,0,0);
			7'h5B: g = mk(2,2,6,3,2,2,2,2,3,0);
			7'h5C: g = mk(3,2,6,4,4,2,2,1,1,0);
			7'h5D: g = mk(2,2,6,3,1,1,1,1,3,0);
			7'h5E: g = mk(3,6,2,2,5,0,0,0,0,0);
			7'h5F: g = mk(4,1,1,15,0,0,0,0,0,0);
			7'h60: g = mk(2,6,2,2,1,0,0,0,0,0);
			7'h61: g = mk(3,2,3,3,5,3,0,0,0,0);
			7'h62: g = mk(3,2,5,4,4,6,5,6,0,0);
			7'h63: g = mk(3,2,3,3,4,3,0,0,0,0);
			7'h64: g = mk(3,2,5,1,1,3,5,3,0,0);
			7'h65: g = mk(3,1,4,3,7,4,3,0,0,0);
			7'h66: g = mk(3,2,5,1,2,7,2,2,0,0);
			7'h67: g = mk(3,1,4,6,7,1,6,0,0,0);
			7'h68: g = mk(3,2,5,4,4,6,5,5,0,0);
			7'h69: g = mk(3,2,5,2,0,6,2,7,0,0);
			7'h6A: g = mk(2,1,6,1,0,3,1,1,2,0);
			7'h6B: g = mk(3,2,5,4,4,5,6,5,0,0);
			7'h6C: g = mk(2,2,5,2,2,2,2,1,0,0);
			7'h6D: g = mk(5,2,3,26,21,21,0,0,0,0);
			7'h6E: g = mk(3,2,3,6,5,5,0,0,0,0);
			7'h6F: g = mk(3,2,3,2,5,2,0,0,0,0);
			7'h70: g = mk(3,1,4,6,5,6,4,0,0,0);
			7'h71: g = mk(3,1,4,3,5,3,1,0,0,0);
			7'h72: g = mk(3,2,3,5,6,4,0,0,0,0);
			7'h73: g = mk(3,2,4,3,4,1,6,0,0,0);
			7'h74: g = mk(3,2,5,2,7,2,2,2,0,0);
			7'h75: g = mk(3,2,3,5,5,3,0,0,0,0);
			7'h76: g = mk(3,2,3,5,5,2,0,0,0,0);
			7'h77: g = mk(5,2,3,17,21,10,0,0,0,0);
			7'h78: g = mk(3,2,3,5,2,5,0,0,0,0);
			7'h79: g = mk(3,1,4,5,5,2,6,0,0,0);
			7'h7A: g = mk(3,2,4,7,1,4,7,0,0,0);
			7'h7B: g = mk(3,1,7,1,2,2,4,2,2,1);
			7'h7C: g = mk(1,1,7,1,1,1,0,1,1,1);
			7'h7D: g = mk(3,1,7,4,2,2,1,2,2,4);
			7'h7E: g = mk(5,3,3,8,21,2,0,0,0,0);
			default: g = mk(1,7,0,0,0,0,0,0,0,0);
		endcase
		return g;
	endfunction

endpackage

// ===== hw/rtl/bfr_if.sv =====
// Channel interfaces of the bitmap font text renderer.
// Depends on bfr_pkg for field widths.
interface bfr_txt_if import bfr_pkg::*; ();
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] char_code;
	logic [FIELD_W-1:0] next_word_width;
	logic [FIELD_W-1:0] set_x;
	logic [FIELD_W-1:0] set_y;
	modport source(output valid, kind, char_code, next_word_width, set_x, set_y,
		input ready);
	modport sink(input valid, kind, char_code, next_word_width, set_x, set_y,
		output ready);
endinterface

interface bfr_pix_if import bfr_pkg::*; ();
	logic valid;
	logic ready;
	logic [FIELD_W-1:0] pixel_x;
	logic [FIELD_W-1:0] pixel_y;
	logic [COLOR_W-1:0] pixel_color;
	logic last_pixel;
	modport source(output valid, pixel_x, pixel_y, pixel_color, last_pixel,
		input ready);
	modport sink(input valid, pixel_x, pixel_y, pixel_color, last_pixel,
		output ready);
endinterface

interface bfr_cfg_if import bfr_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COLOR_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bfr_cell_unit.sv =====
// Shared cell unit: glyph bit test, absolute position and clip test for one cell.
// Depends on bfr_pkg.
module bfr_cell_unit import bfr_pkg::*; #(
	parameter int CW = 16
) (
	input glyph_t g,
	input cell_req_t req,
	input logic [CW-1:0] col,
	input logic [CW-1:0] row,
	input logic [FIELD_W-1:0] clip_x0,
	input logic [FIELD_W-1:0] clip_y0,
	input logic [FIELD_W-1:0] clip_width,
	input logic [FIELD_W-1:0] clip_height,
	output logic emit,
	output logic [FIELD_W-1:0] px,
	output logic [FIELD_W-1:0] py
);
	localparam int XW = ((CW > FIELD_W) ? CW : FIELD_W) + 2;

	logic [2:0] sy, r, ridx, bidx;
	logic on_row, bit_set, in_box, cell_on;
	logic [CW:0] ax, ay;
	logic [XW-1:0] ex, ey, xlo, xhi, ylo, yhi;
	logic in_clip;

	always_comb begin
		sy = LINE_H - g.off;
		r = sy - req.y;
		ridx = g.n - 3'd1 - r;
		bidx = g.w - 3'd1 - req.x;
		on_row = (req.y <= sy) && (r < g.n) && (req.x < g.w);
		bit_set = on_row && g.rows[ridx][bidx];
		in_box = (req.x < g.w) && (req.y <= sy);
		cell_on = req.inv ? (!in_box || !bit_set) : bit_set;
		ax = {1'b0, col} + (CW+1)'(req.x);
		ay = {1'b0, row} + (CW+1)'(req.y);
		ex = XW'(ax);
		ey = XW'(ay);
		xlo = XW'(clip_x0);
		ylo = XW'(clip_y0);
		xhi = XW'(clip_x0) + XW'(clip_width);
		yhi = XW'(clip_y0) + XW'(clip_height);
		// drop cells past the coordinate range
		in_clip = !ax[CW] && !ay[CW] && (ex >= xlo) && (ex < xhi)
			&& (ey >= ylo) && (ey < yhi);
		emit = cell_on && in_clip;
		px = FIELD_W'(ax[CW-1:0]);
		py = FIELD_W'(ay[CW-1:0]);
	end
endmodule

// ===== hw/rtl/bfr_out_stage.sv =====
// Output stage: one pending pixel plus the output register, so the final
// pixel of a character can be marked. Depends on bfr_pkg and bfr_if.
module bfr_out_stage import bfr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input ostage_ctrl_t ctrl,
	input logic [FIELD_W-1:0] px,
	input logic [FIELD_W-1:0] py,
	input logic [COLOR_W-1:0] color,
	output ostage_stat_t stat,
	bfr_pix_if.source pix
);
	logic pend_v_q, out_v_q, out_last_q;
	logic [FIELD_W-1:0] pend_x_q, pend_y_q, out_x_q, out_y_q;
	logic [COLOR_W-1:0] out_c_q;
	logic out_free, push_ok, move;

	assign out_free = !out_v_q || pix.ready;
	assign push_ok = !pend_v_q || out_free;
	assign move = pend_v_q && out_free && ((ctrl.push && push_ok) || ctrl.flush);
	assign stat.push_ok = push_ok;
	assign stat.pend_v = pend_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (move) out_v_q <= 1'b1;
			else if (pix.ready) out_v_q <= 1'b0;
			if (ctrl.push && push_ok) pend_v_q <= 1'b1;
			else if (move) pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push && push_ok) begin
			pend_x_q <= px;
			pend_y_q <= py;
		end
		if (move) begin
			out_x_q <= pend_x_q;
			out_y_q <= pend_y_q;
			out_c_q <= color;
			out_last_q <= ctrl.flush && !ctrl.push;
		end
	end

	assign pix.valid = out_v_q;
	assign pix.pixel_x = out_x_q;
	assign pix.pixel_y = out_y_q;
	assign pix.pixel_color = out_c_q;
	assign pix.last_pixel = out_last_q;
endmodule

// ===== hw/rtl/bitmap_font_text_renderer_top.sv =====
// Bitmap font text renderer, top level.
// A draw item is accepted, then decoded, then each glyph cell is scanned in turn (up to 48
// cells for an inverted box), then the last pixel is flushed; output backpressure stalls
// the scan and the flush. A cursor set ends at accept; undrawn codes end after decode.
// The single cell unit visits one cell a cycle unless stalled, which sets the rate.
// Reset: cursor 0,0; registers return to their documented defaults.
module bitmap_font_text_renderer_top import bfr_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	bfr_cfg_if.sink cfg,
	bfr_txt_if.sink txt_in,
	bfr_pix_if.source pix_out
);
	localparam int CW = COORD_WIDTH;
	localparam int WW = ((CW > FIELD_W) ? CW : FIELD_W) + 2;

	seq_state_t state_q, state_nxt;
	logic [COLOR_W-1:0] text_color_q;
	logic [FIELD_W-1:0] clip_x0_q, clip_y0_q, clip_width_q, clip_height_q;
	logic [3:0] mode_q;
	logic [CW-1:0] col_q, row_q, col_nxt, row_nxt;
	logic [7:0] code_q;
	logic [FIELD_W-1:0] nww_q;
	glyph_t g_q, g_dec;
	logic inv_q;
	logic [2:0] x_q, y_q, x_nxt, y_nxt;
	logic [6:0] ch;
	logic [CW:0] row_adv, col_adv;
	logic [WW-1:0] word_end, letter_end;
	logic accept, load_glyph, advance;
	cell_req_t req;
	ostage_ctrl_t octrl;
	ostage_stat_t ostat;
	logic emit;
	logic [FIELD_W-1:0] px, py;

	assign cfg.ready = 1'b1;
	assign txt_in.ready = (state_q == ST_IDLE);
	assign accept = txt_in.valid && txt_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= 24'hFFFFFF;
			clip_x0_q <= '0;
			clip_y0_q <= '0;
			clip_width_q <= 16'd640;
			clip_height_q <= 16'd480;
			mode_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TEXT_COLOR: text_color_q <= cfg.data;
				REG_CLIP_X0: clip_x0_q <= cfg.data[FIELD_W-1:0];
				REG_CLIP_Y0: clip_y0_q <= cfg.data[FIELD_W-1:0];
				REG_CLIP_WIDTH: clip_width_q <= cfg.data[FIELD_W-1:0];
				REG_CLIP_HEIGHT: clip_height_q <= cfg.data[FIELD_W-1:0];
				REG_MODE_FLAGS: mode_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	assign ch = code_q[6:0];
	assign g_dec = glyph_lookup(ch);
	assign row_adv = {1'b0, row_q} + (CW+1)'(LINE_ADV);
	assign col_adv = {1'b0, col_q} + (CW+1)'(g_q.w) + (CW+1)'(1);
	assign word_end = WW'(nww_q) + WW'(col_q);
	assign letter_end = WW'(col_q) + WW'(g_dec.w);
	assign req = '{inv: inv_q, x: x_q, y: y_q};

	bfr_cell_unit #(.CW(CW)) u_cell (
		.g(g_q), .req(req), .col(col_q), .row(row_q),
		.clip_x0(clip_x0_q), .clip_y0(clip_y0_q),
		.clip_width(clip_width_q), .clip_height(clip_height_q),
		.emit(emit), .px(px), .py(py)
	);

	bfr_out_stage u_out (
		.clk(clk), .arst_n(arst_n), .ctrl(octrl), .px(px), .py(py),
		.color(text_color_q), .stat(ostat), .pix(pix_out)
	);

	always_comb begin
		state_nxt = state_q;
		col_nxt = col_q;
		row_nxt = row_q;
		load_glyph = 1'b0;
		x_nxt = x_q;
		y_nxt = y_q;
		advance = 1'b0;
		octrl = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (txt_in.kind) begin
						col_nxt = CW'(txt_in.set_x);
						row_nxt = CW'(txt_in.set_y);
					end else begin
						state_nxt = ST_DECODE;
					end
				end
			end
			ST_DECODE: begin
				state_nxt = ST_IDLE;
				if (ch == CH_SPACE && mode_q[1] && word_end > WW'(clip_width_q)) begin
					col_nxt = '0;
					row_nxt = row_adv[CW] ? '1 : row_adv[CW-1:0];
				end else if (ch < CH_SPACE || ch > CH_LAST_PRINT) begin
					if (mode_q[3] && ch == CH_NEWLINE) begin
						col_nxt = '0;
						row_nxt = row_adv[CW] ? '1 : row_adv[CW-1:0];
					end
				end else begin
					load_glyph = 1'b1;
					state_nxt = ST_SCAN;
					if (mode_q[2] && letter_end > WW'(clip_width_q)) begin
						col_nxt = '0;
						row_nxt = row_adv[CW] ? '1 : row_adv[CW-1:0];
					end
					if (mode_q[0] && code_q[7]) begin
						x_nxt = g_dec.w;
						y_nxt = LINE_H;
					end else begin
						x_nxt = g_dec.w - 3'd1;
						y_nxt = LINE_H - g_dec.off;
					end
				end
			end
			ST_SCAN: begin
				octrl.push = emit;
				advance = !emit || ostat.push_ok;
				if (advance) begin
					if (x_q == 3'd0) begin
						if (y_q == 3'd0) begin
							state_nxt = ST_FLUSH;
							col_nxt = col_adv[CW] ? '1 : col_adv[CW-1:0];
						end else begin
							y_nxt = y_q - 3'd1;
							x_nxt = inv_q ? g_q.w : g_q.w - 3'd1;
						end
					end else begin
						x_nxt = x_q - 3'd1;
					end
				end
			end
			ST_FLUSH: begin
				octrl.flush = 1'b1;
				if (!ostat.pend_v) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= '0;
			row_q <= '0;
		end else begin
			state_q <= state_nxt;
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= txt_in.char_code;
			nww_q <= txt_in.next_word_width;
		end
		if (load_glyph) begin
			g_q <= g_dec;
			inv_q <= mode_q[0] && code_q[7];
		end
		x_q <= x_nxt;
		y_q <= y_nxt;
	end

	// a new item is taken only once no pixel of the previous one is pending
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		txt_in.ready |-> !ostat.pend_v) else $error("pending pixel at idle");
	// scan column never passes the box width
	a_scan_x: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> x_q <= g_q.w) else $error("scan column out of range");
	// cursor stays put while the glyph is scanned
	a_cursor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && $past(state_q) == ST_SCAN) |-> $stable(col_q) && $stable(row_q))
		else $error("cursor moved mid-scan");
	// flush leads back to idle only with the pending slot drained
	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && state_nxt == ST_IDLE) |-> !ostat.pend_v)
		else $error("left flush with pixel pending");
endmodule
